[hdl/wes_pkg.sv]
// ----------------------------------------------------------------------------
// wes_pkg
// Types, constants and helper functions of the wave elevation sum-of-sines unit.
// ----------------------------------------------------------------------------
package wes_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST_A,
    ST_DIST_B,
    ST_DIST_C,
    ST_XOG,
    ST_TAU,
    ST_RUN,
    ST_SUM,
    ST_RAMP_F,
    ST_RAMP_S,
    ST_OUT
  } wes_state_e;

  typedef enum logic [2:0] {
    CFG_COS_HEADING  = 3'd0,
    CFG_SIN_HEADING  = 3'd1,
    CFG_VESSEL_SPEED = 3'd2,
    CFG_INV_GRAVITY  = 3'd3,
    CFG_RAMP_TIME    = 3'd4,
    CFG_INV_RAMP     = 3'd5,
    CFG_NUM_COMP     = 3'd6
  } wes_cfg_e;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  // Angle constants in Q.32 radians.
  localparam logic [63:0]        TWO_PI_Q32  = 64'd26986075409;
  localparam logic signed [36:0] TWO_PI_S    = 37'sd26986075409;
  localparam logic signed [36:0] PI_S        = 37'sd13493037705;
  localparam logic signed [36:0] HALF_PI_S   = 37'sd6746518852;

  localparam int                 CORDIC_STEPS = 16;
  localparam logic signed [19:0] CORDIC_GAIN  = 20'sd39797;

  // Range reduction steps: subtract 2*pi*2^k for k = RED_STEPS-1 down to 0.
  localparam int RED_STEPS = 29;

  // Valid pipeline: read data, phase, offset, reduction, fold, CORDIC, product.
  localparam int NSTG = 3 + RED_STEPS + 1 + CORDIC_STEPS + 1;

  function automatic logic signed [19:0] atan_q16(input int i);
    logic signed [19:0] a;
    case (i)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      default: a = 20'sd0;
    endcase
    return a;
  endfunction

  // Saturate to 32 signed bits; the top bit of the result flags overflow.
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

[hdl/wave_elevation_sum_of_sines_unit.sv]
// ----------------------------------------------------------------------------
// wave_elevation_sum_of_sines_unit
// Wave elevation as a saturated sum of sinusoidal components in Q16.16.
// ----------------------------------------------------------------------------
// A load transaction (tuser = 0) writes one component into the table. An
// evaluate transaction (tuser = 1) passes through the states DIST_A, DIST_B
// and DIST_C, which form the travelled distance one product at a time, XOG,
// which scales it by the inverse gravity, and TAU, which forms the delayed
// time tau. Then the component table, held in one synchronous memory, is read
// one slot per cycle into a 50-stage pipeline (read register, phase multiply,
// sign offset, 29 stages of modulo 2*pi reduction, quadrant fold, 16 CORDIC
// rotations, amplitude multiply) that feeds the accumulator. After the
// pipeline drains, the sum is saturated and, during the ramp, scaled by
// t * inv_ramp_time in the states RAMP_F and RAMP_S. The result sits in an
// output register, so the next transaction is taken while it waits. One
// evaluation is in flight at a time: s_axis_tready is high only in the idle
// state.
module wave_elevation_sum_of_sines_unit
  import wes_pkg::*;
#(
  parameter int MAX_COMPONENTS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: comp_index[9:0], comp_ampl, comp_omega, comp_phase,
  // pos_x, pos_y, disp_x, disp_y, time_t (32 bits each), 6 zero bits.
  input  logic [271:0] s_axis_tdata,
  // tuser: req_type (0 load, 1 evaluate).
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: elevation[31:0].
  output logic [31:0]  m_axis_tdata,
  // tuser: saturated flag.
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CW = $clog2(MAX_COMPONENTS + 1);
  localparam int XW = 18;
  localparam logic [XW-1:0] MAXC = XW'(MAX_COMPONENTS);
  localparam logic [63:0] RED_OFS = TWO_PI_Q32 << (RED_STEPS - 1);

  // Configuration registers.
  logic signed [17:0] cos_q, sin_q;
  logic signed [31:0] vs_q;
  logic [15:0]        invg_q;
  logic [30:0]        ramp_q, invramp_q;
  logic [10:0]        ncomp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q     <= -18'sd65536;
      sin_q     <= '0;
      vs_q      <= '0;
      invg_q    <= 16'd6680;
      ramp_q    <= '0;
      invramp_q <= '0;
      ncomp_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (wes_cfg_e'(cfg_addr_i))
        CFG_COS_HEADING:  cos_q     <= cfg_data_i[17:0];
        CFG_SIN_HEADING:  sin_q     <= cfg_data_i[17:0];
        CFG_VESSEL_SPEED: vs_q      <= cfg_data_i;
        CFG_INV_GRAVITY:  invg_q    <= cfg_data_i[15:0];
        CFG_RAMP_TIME:    ramp_q    <= cfg_data_i[30:0];
        CFG_INV_RAMP:     invramp_q <= cfg_data_i[30:0];
        CFG_NUM_COMP:     ncomp_q   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [9:0]         in_idx;
  logic [95:0]        in_comp;
  logic signed [31:0] in_px, in_py, in_dx, in_dy, in_t;
  assign in_idx  = s_axis_tdata[9:0];
  assign in_comp = s_axis_tdata[105:10];
  assign in_px   = s_axis_tdata[137:106];
  assign in_py   = s_axis_tdata[169:138];
  assign in_dx   = s_axis_tdata[201:170];
  assign in_dy   = s_axis_tdata[233:202];
  assign in_t    = s_axis_tdata[265:234];

  wes_state_e state_q, state_d;
  logic       in_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Component memory: {phase, omega, amplitude} per slot.
  logic [95:0]    mem [MAX_COMPONENTS];
  logic [95:0]    rd_q;
  logic [AW+9:0]  widx_ext;
  logic [AW-1:0]  waddr;
  logic           mem_we;
  logic [CW-1:0]  cnt_q, n_q;

  assign widx_ext = {{AW{1'b0}}, in_idx};
  assign waddr    = widx_ext[AW-1:0];
  assign mem_we   = in_acc && (s_axis_tuser == REQ_LOAD) && ({8'd0, in_idx} < MAXC);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= in_comp;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[cnt_q[AW-1:0]];
  end

  // Front-end and scaling datapath.
  logic signed [32:0] sx_q, sy_q;
  logic signed [31:0] t_q, tau_q, res_q, f_q;
  logic signed [63:0] dist_q, xog_q;
  logic signed [59:0] acc_q;
  logic               flag_q, ramp_en;
  logic [XW-1:0]      n_ext, n_clip;
  logic [32:0]        sat_tau, sat_sum, sat_f, sat_r;
  logic signed [63:0] xog_prod;

  assign n_ext  = {7'd0, ncomp_q};
  assign n_clip = (n_ext > MAXC) ? MAXC : n_ext;
  assign xog_prod = (dist_q >>> 16) * $signed({48'd0, invg_q});
  assign sat_tau = sat32(64'(t_q) - xog_q);
  assign sat_sum = sat32(64'(acc_q >>> 16));
  assign sat_f   = sat32((64'(t_q) * $signed({33'd0, invramp_q})) >>> 16);
  assign sat_r   = sat32((64'(res_q) * 64'(f_q)) >>> 16);
  assign ramp_en = (ramp_q != '0) && ($signed({t_q[31], t_q}) < $signed({2'b0, ramp_q}));

  // Pipeline valid bits.
  logic [NSTG-1:0] vld_q;
  logic            issue, drained;
  assign issue   = (state_q == ST_RUN) && (cnt_q < n_q);
  assign drained = (state_q == ST_RUN) && (cnt_q == n_q) && (vld_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc && s_axis_tuser == REQ_EVAL) state_d = ST_DIST_A;
      ST_DIST_A: state_d = ST_DIST_B;
      ST_DIST_B: state_d = ST_DIST_C;
      ST_DIST_C: state_d = ST_XOG;
      ST_XOG:    state_d = ST_TAU;
      ST_TAU:    state_d = ST_RUN;
      ST_RUN:    if (drained) state_d = ST_SUM;
      ST_SUM:    state_d = ramp_en ? ST_RAMP_F : ST_OUT;
      ST_RAMP_F: state_d = ST_RAMP_S;
      ST_RAMP_S: state_d = ST_OUT;
      ST_OUT:    if (!m_axis_tvalid || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= '0;
      cnt_q   <= '0;
      flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= {vld_q[NSTG-2:0], issue};
      if (state_q == ST_TAU) cnt_q <= '0;
      else if (issue)        cnt_q <= cnt_q + 1'b1;
      if (state_q == ST_IDLE)     flag_q <= 1'b0;
      if (state_q == ST_TAU)      flag_q <= flag_q | sat_tau[32];
      if (state_q == ST_SUM)      flag_q <= flag_q | sat_sum[32];
      if (state_q == ST_RAMP_F)   flag_q <= flag_q | sat_f[32];
      if (state_q == ST_RAMP_S)   flag_q <= flag_q | sat_r[32];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        sx_q <= 33'(in_px) + 33'(in_dx);
        sy_q <= 33'(in_py) + 33'(in_dy);
        t_q  <= in_t;
        n_q  <= n_clip[CW-1:0];
      end
      ST_DIST_A: dist_q <= 64'(sx_q) * 64'(cos_q);
      ST_DIST_B: dist_q <= dist_q + 64'(sy_q) * 64'(sin_q);
      ST_DIST_C: dist_q <= dist_q + 64'(vs_q) * 64'(t_q);
      ST_XOG:    xog_q  <= xog_prod >>> 16;
      ST_TAU: begin
        tau_q <= sat_tau[31:0];
        acc_q <= '0;
      end
      ST_SUM:    res_q <= sat_sum[31:0];
      ST_RAMP_F: f_q   <= sat_f[31:0];
      ST_RAMP_S: res_q <= sat_r[31:0];
      default: ;
    endcase
    if (vld_q[NSTG-1]) acc_q <= acc_q + 60'(term_q);
  end

  // Sine pipeline. The amplitude delay line keeps each amplitude beside its
  // sine, so the last entry lines up with the final CORDIC stage.
  logic signed [31:0] rd_ampl, rd_omega, rd_phase;
  logic signed [31:0] amp_q [NSTG-2];
  logic signed [63:0] ph_q;
  logic [63:0]        red_q [RED_STEPS+1];
  logic signed [19:0] cx_q [CORDIC_STEPS+1];
  logic signed [19:0] cy_q [CORDIC_STEPS+1];
  logic signed [19:0] cz_q [CORDIC_STEPS+1];
  logic signed [49:0] term_q;
  logic signed [36:0] r0, r1, r2, zr;
  logic signed [17:0] y_clamp;

  assign rd_ampl  = rd_q[31:0];
  assign rd_omega = rd_q[63:32];
  assign rd_phase = rd_q[95:64];

  // Fold the reduced angle into [-pi/2, pi/2] and clamp the CORDIC sine to [-1, 1].
  always_comb begin
    r0 = $signed({2'b00, red_q[RED_STEPS][34:0]});
    r1 = (r0 > PI_S) ? r0 - TWO_PI_S : r0;
    if (r1 > HALF_PI_S)       r2 = PI_S - r1;
    else if (r1 < -HALF_PI_S) r2 = -PI_S - r1;
    else                      r2 = r1;
    zr = r2 >>> 16;
    if (cy_q[CORDIC_STEPS] > 20'sd65536)       y_clamp = 18'sd65536;
    else if (cy_q[CORDIC_STEPS] < -20'sd65536) y_clamp = -18'sd65536;
    else                                      y_clamp = cy_q[CORDIC_STEPS][17:0];
  end

  always_ff @(posedge clk_i) begin
    amp_q[0] <= rd_ampl;
    for (int d = 1; d < NSTG - 2; d++) begin
      amp_q[d] <= amp_q[d-1];
    end
    ph_q     <= 64'(rd_omega) * 64'(tau_q) + {{16{rd_phase[31]}}, rd_phase, 16'd0};
    red_q[0] <= ph_q[63] ? 64'(ph_q) + RED_OFS : 64'(ph_q);
    for (int j = 1; j <= RED_STEPS; j++) begin
      if (red_q[j-1] >= (TWO_PI_Q32 << (RED_STEPS - j))) begin
        red_q[j] <= red_q[j-1] - (TWO_PI_Q32 << (RED_STEPS - j));
      end else begin
        red_q[j] <= red_q[j-1];
      end
    end
    cx_q[0] <= CORDIC_GAIN;
    cy_q[0] <= '0;
    cz_q[0] <= zr[19:0];
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (cz_q[i] >= 0) begin
        cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] - atan_q16(i);
      end else begin
        cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] + atan_q16(i);
      end
    end
    term_q <= 50'(amp_q[NSTG-3]) * 50'(y_clamp);
  end

  // Output register.
  logic        ov_q, osat_q;
  logic [31:0] oel_q;
  logic        out_load;
  assign out_load = (state_q == ST_OUT) && (!ov_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oel_q  <= res_q;
      osat_q <= flag_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = oel_q;
  assign m_axis_tuser  = osat_q;

  // The pipeline is empty whenever a new transaction can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (vld_q == '0))
    else $error("pipeline busy while accepting");

  // The slot counter never runs past the clipped component count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= n_q))
    else $error("slot counter overrun");

  // A new result appears only after the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result without evaluation");

  // Terms reach the accumulator only while the table is being walked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTG-1] |-> (state_q == ST_RUN))
    else $error("term outside run phase");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the wave elevation sum-of-sines unit.
// A short table of directed transactions covers the reset state, the field
// extremes, tau and ramp saturation, negative time in the ramp and headings
// outside the unit range. The first table slots are then filled, and random
// phases follow, each with its own register settings. Every result is compared
// against an expected value from its row or an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module tb;
  import wes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int           NUM_SLOTS    = 1024;
  localparam int           NUM_FILL     = 64;
  localparam int           IDLE_LIMIT   = 20000;
  localparam int           ITEMS_PHASE  = 75;
  localparam int           NUM_PHASES   = 8;
  localparam longint       TWO_PI_FIX   = 64'sd26986075409;
  localparam longint       PI_FIX       = 64'sd13493037705;
  localparam longint       HALF_PI_FIX  = 64'sd6746518852;
  localparam longint       ROT_GAIN     = 64'sd39797;
  localparam logic [31:0]  S32_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0]  S32_MIN      = 32'h8000_0000;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EVAL} row_kind_e;

  typedef struct {
    logic        req;
    logic [9:0]  slot;
    logic [31:0] ampl;
    logic [31:0] omega;
    logic [31:0] phase;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] disp_x;
    logic [31:0] disp_y;
    logic [31:0] t;
  } wave_req_t;

  typedef struct {
    row_kind_e   kind;
    wes_cfg_e    addr;
    logic [31:0] value;
    wave_req_t   req;
    bit          typed;
    logic [31:0] typed_elev;
    bit          typed_sat;
  } stim_row_t;

  typedef struct {
    logic [31:0] elev;
    bit          sat;
  } elev_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [271:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_addr_i;
  logic [31:0]  cfg_data_i;

  wave_elevation_sum_of_sines_unit dut (.*);

  // Model state: component tables and register copies.
  logic [31:0]  amp_tab  [NUM_SLOTS];
  logic [31:0]  freq_tab [NUM_SLOTS];
  logic [31:0]  ph_tab   [NUM_SLOTS];
  longint       heading_cos, heading_sin, speed, inv_g, ramp_len, inv_ramp, comp_count;
  longint       atan_tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2};

  elev_result_t pending_elev[$];
  stim_row_t    stim_table[$];
  int           mismatches, loads_sent, evals_sent, results_seen, sat_seen;
  int           idle_cycles;
  bit           no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic longint clamp_s32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Sine in Q.16 of an angle in Q.32 radians: fold into [-pi/2, pi/2], rotate, clamp.
  function automatic longint rot_sine(longint angle);
    longint r, x, y, z, dx, dy;
    r = angle % TWO_PI_FIX;
    x = ROT_GAIN;
    y = 0;
    if (r < 0) r += TWO_PI_FIX;
    if (r > PI_FIX) r -= TWO_PI_FIX;
    if (r > HALF_PI_FIX) r = PI_FIX - r;
    else if (r < -HALF_PI_FIX) r = -PI_FIX - r;
    z = r >>> 16;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_tab[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tab[i];
      end
    end
    if (y > 65536) y = 65536;
    if (y < -65536) y = -65536;
    return y;
  endfunction

  function automatic void set_register(wes_cfg_e addr, logic [31:0] v);
    case (addr)
      CFG_COS_HEADING:  heading_cos = longint'($signed(v[17:0]));
      CFG_SIN_HEADING:  heading_sin = longint'($signed(v[17:0]));
      CFG_VESSEL_SPEED: speed = longint'($signed(v));
      CFG_INV_GRAVITY:  inv_g = longint'(v[15:0]);
      CFG_RAMP_TIME:    ramp_len = longint'(v[30:0]);
      CFG_INV_RAMP:     inv_ramp = longint'(v[30:0]);
      CFG_NUM_COMP:     comp_count = longint'(v[10:0]);
      default: ;
    endcase
  endfunction

  function automatic elev_result_t wave_elevation(wave_req_t q);
    elev_result_t res;
    bit     flag;
    longint sx, sy, t, distance, xog, tau, acc, sum, f, n;
    flag = 1'b0;
    n  = (comp_count > NUM_SLOTS) ? NUM_SLOTS : comp_count;
    sx = longint'($signed(q.pos_x)) + longint'($signed(q.disp_x));
    sy = longint'($signed(q.pos_y)) + longint'($signed(q.disp_y));
    t  = longint'($signed(q.t));
    distance = sx * heading_cos + sy * heading_sin + speed * t;
    xog  = ((distance >>> 16) * inv_g) >>> 16;
    tau  = clamp_s32(t - xog, flag);
    acc  = 0;
    for (int k = 0; k < n; k++) begin
      acc += longint'($signed(amp_tab[k])) *
             rot_sine(longint'($signed(freq_tab[k])) * tau +
                      longint'($signed(ph_tab[k])) * 65536);
    end
    sum = clamp_s32(acc >>> 16, flag);
    if (ramp_len > 0 && t < ramp_len) begin
      f   = clamp_s32((t * inv_ramp) >>> 16, flag);
      sum = clamp_s32((sum * f) >>> 16, flag);
    end
    res.elev = sum[31:0];
    res.sat  = flag;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_small(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic stim_row_t cfg_row(wes_cfg_e addr, logic [31:0] v);
    stim_row_t r;
    r = '{kind: ROW_CFG, addr: CFG_COS_HEADING, req: '{default: '0}, default: '0};
    r.kind  = ROW_CFG;
    r.addr  = addr;
    r.value = v;
    return r;
  endfunction

  function automatic stim_row_t load_row(logic [9:0] slot, logic [31:0] a, logic [31:0] w,
                                         logic [31:0] p);
    stim_row_t r;
    r = '{kind: ROW_LOAD, addr: CFG_COS_HEADING, req: '{default: '0}, default: '0};
    r.kind      = ROW_LOAD;
    r.req.req   = REQ_LOAD;
    r.req.slot  = slot;
    r.req.ampl  = a;
    r.req.omega = w;
    r.req.phase = p;
    return r;
  endfunction

  function automatic stim_row_t eval_row(logic [31:0] x, logic [31:0] y, logic [31:0] dx,
                                         logic [31:0] dy, logic [31:0] t);
    stim_row_t r;
    r = '{kind: ROW_EVAL, addr: CFG_COS_HEADING, req: '{default: '0}, default: '0};
    r.kind       = ROW_EVAL;
    r.req.req    = REQ_EVAL;
    r.req.pos_x  = x;
    r.req.pos_y  = y;
    r.req.disp_x = dx;
    r.req.disp_y = dy;
    r.req.t      = t;
    return r;
  endfunction

  function automatic stim_row_t typed_eval(stim_row_t r, logic [31:0] elev, bit sat);
    r.typed      = 1'b1;
    r.typed_elev = elev;
    r.typed_sat  = sat;
    return r;
  endfunction

  // Register writes happen only with the unit idle: every result in and a settling
  // wait for any trailing load transaction to retire.
  task automatic write_register(wes_cfg_e addr, logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_elev.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_register(addr, v);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one request; tvalid stays high when the next one follows at once.
  task automatic send_request(wave_req_t q, bit typed, logic [31:0] t_elev, bit t_sat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.req;
    s_axis_tdata  <= {6'b0, q.t, q.disp_y, q.disp_x, q.pos_y, q.pos_x,
                      q.phase, q.omega, q.ampl, q.slot};
    do @(posedge clk_i); while (!s_axis_tready);
    if (q.req == REQ_LOAD) begin
      amp_tab[q.slot]  = q.ampl;
      freq_tab[q.slot] = q.omega;
      ph_tab[q.slot]   = q.phase;
      loads_sent++;
    end else begin
      elev_result_t e;
      e = wave_elevation(q);
      if (typed) begin
        e.elev = t_elev;
        e.sat  = t_sat;
      end
      pending_elev.push_back(e);
      evals_sent++;
    end
  endtask

  task automatic apply_row(stim_row_t r);
    if (r.kind == ROW_CFG) write_register(r.addr, r.value);
    else send_request(r.req, r.typed, r.typed_elev, r.typed_sat);
  endtask

  function automatic wave_req_t random_request();
    wave_req_t q;
    int        r;
    q = '{default: '0};
    r = $urandom_range(0, 9);
    if (r < 3) begin
      q.req   = REQ_LOAD;
      q.slot  = $urandom_range(0, NUM_FILL - 1);
      q.ampl  = ($urandom_range(0, 3) == 0) ? $urandom() : rand_small(32'h0004_0000);
      q.omega = $urandom();
      q.phase = $urandom();
    end else begin
      q.req    = REQ_EVAL;
      q.pos_x  = ($urandom_range(0, 3) == 0) ? $urandom() : rand_small(32'h0020_0000);
      q.pos_y  = ($urandom_range(0, 3) == 0) ? $urandom() : rand_small(32'h0020_0000);
      q.disp_x = ($urandom_range(0, 3) == 0) ? $urandom() : rand_small(32'h0002_0000);
      q.disp_y = ($urandom_range(0, 3) == 0) ? $urandom() : rand_small(32'h0002_0000);
      q.t      = ($urandom_range(0, 3) == 0) ? $urandom() : rand_small(32'h0018_0000);
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  initial begin
    // After reset no component is summed and nothing saturates.
    stim_table.push_back(typed_eval(eval_row(0, 0, 0, 0, 0), 32'd0, 1'b0));
    // Most negative time at the most negative x drives tau below range.
    stim_table.push_back(typed_eval(eval_row(S32_MIN, 0, 0, 0, S32_MIN), 32'd0, 1'b1));
    stim_table.push_back(load_row(10'd0, S32_MAX, S32_MAX, S32_MAX));
    stim_table.push_back(load_row(10'd1, S32_MIN, S32_MIN, S32_MIN));
    stim_table.push_back(load_row(10'd1023, 32'hFFFF_FFFF, 32'h0001_0000, 32'd0));
    stim_table.push_back(cfg_row(CFG_NUM_COMP, 32'd2));
    stim_table.push_back(eval_row(32'h0003_0000, 32'h0001_8000, 32'h0000_4000,
                                  32'hFFFF_C000, 32'h0002_0000));
    stim_table.push_back(eval_row(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX));
    stim_table.push_back(eval_row(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN));
    // Heading values outside the unit circle are used unchanged.
    stim_table.push_back(cfg_row(CFG_COS_HEADING, 32'h0001_FFFF));
    stim_table.push_back(cfg_row(CFG_SIN_HEADING, 32'h0002_0000));
    stim_table.push_back(eval_row(32'h0010_0000, 32'hFFF0_0000, 0, 0, 32'h0001_0000));
    // Ramp over ten seconds: inside, negative time, and past the ramp.
    stim_table.push_back(cfg_row(CFG_RAMP_TIME, 32'h000A_0000));
    stim_table.push_back(cfg_row(CFG_INV_RAMP, 32'd6554));
    stim_table.push_back(eval_row(32'h0001_0000, 0, 0, 0, 32'h0005_0000));
    stim_table.push_back(eval_row(32'h0001_0000, 0, 0, 0, 32'hFFFD_0000));
    stim_table.push_back(eval_row(32'h0001_0000, 0, 0, 0, 32'h0014_0000));
    // Largest ramp settings push the factor out of range.
    stim_table.push_back(cfg_row(CFG_RAMP_TIME, 32'h7FFF_FFFF));
    stim_table.push_back(cfg_row(CFG_INV_RAMP, 32'h7FFF_FFFF));
    stim_table.push_back(eval_row(32'h0002_0000, 0, 0, 0, 32'h7FFF_FFFE));
    stim_table.push_back(cfg_row(CFG_VESSEL_SPEED, S32_MAX));
    stim_table.push_back(cfg_row(CFG_INV_GRAVITY, 32'h0000_FFFF));
    stim_table.push_back(eval_row(0, 0, 0, 0, S32_MIN));
    stim_table.push_back(cfg_row(CFG_VESSEL_SPEED, S32_MIN));
    stim_table.push_back(cfg_row(CFG_INV_GRAVITY, 32'd0));
    stim_table.push_back(eval_row(32'h1234_5678, 32'h8765_4321, 0, 0, 32'h0003_0000));
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    wes_cfg_e addr;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_LOAD;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = CFG_COS_HEADING;
    cfg_data_i    = '0;
    no_idle       = 1'b0;
    heading_cos = -65536;
    heading_sin = 0;
    speed       = 0;
    inv_g       = 6680;
    ramp_len    = 0;
    inv_ramp    = 0;
    comp_count  = 0;
    foreach (amp_tab[k]) begin
      amp_tab[k]  = '0;
      freq_tab[k] = '0;
      ph_tab[k]   = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) apply_row(stim_table[i]);

    // Fill the first slots so that every component count below only reads
    // written entries.
    for (int k = 0; k < NUM_FILL; k++) begin
      apply_row(load_row(k[9:0], rand_small(32'h0008_0000), $urandom(), $urandom()));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      no_idle = (p % 3 == 2);
      write_register(CFG_COS_HEADING, (p == 0) ? 32'h0001_0000 :
                     (p == 1) ? 32'hFFFF_0000 : rand_small(65536));
      write_register(CFG_SIN_HEADING, (p == 2) ? 32'h0001_0000 :
                     (p == 3) ? 32'hFFFF_0000 : rand_small(65536));
      write_register(CFG_VESSEL_SPEED, (p == 4) ? $urandom() : rand_small(32'h0008_0000));
      write_register(CFG_INV_GRAVITY, (p == 5) ? 32'h0000_FFFF :
                     (p == 6) ? 32'd0 : $urandom_range(1000, 12000));
      write_register(CFG_RAMP_TIME, (p % 2 == 1) ? 32'h000A_0000 : 32'd0);
      write_register(CFG_INV_RAMP, (p % 2 == 1) ? 32'd6554 : 32'd0);
      // Counts of zero, one, a few, half and all of the filled slots.
      case (p)
        0:       addr = CFG_NUM_COMP;
        default: addr = CFG_NUM_COMP;
      endcase
      write_register(addr, (p == 0) ? 32'd1 : (p == 3) ? 32'(NUM_FILL) :
                     (p == 6) ? 32'(NUM_FILL / 2) : (p == 7) ? 32'd0 :
                     $urandom_range(2, 16));
      for (int i = 0; i < ((p == 3 || p == 6) ? 20 : ITEMS_PHASE); i++) begin
        send_request(random_request(), 1'b0, 32'd0, 1'b0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_elev.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d load and %0d evaluate transactions over %0d register phases,",
             loads_sent, evals_sent, NUM_PHASES);
    $display("%0d results checked, %0d saturated, %0d mismatches.",
             results_seen, sat_seen, mismatches);
    if (mismatches == 0 && pending_elev.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and checking
  // ---------------------------------------------------------------------------
  initial begin
    int g;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser) sat_seen++;
      if (pending_elev.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected result elevation=%h saturated=%b",
                   m_axis_tdata, m_axis_tuser);
        end
      end else begin
        elev_result_t e;
        e = pending_elev.pop_front();
        if (m_axis_tdata !== e.elev || m_axis_tuser !== e.sat) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d elevation exp %h got %h, saturated exp %b got %b",
                     results_seen, e.elev, m_axis_tdata, e.sat, m_axis_tuser);
          end
        end
      end
    end
  end

  // The watchdog ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
